/* hdl/sqm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sqm_pkg;

  localparam int JobStepBits = 24;

  // Register indexes on the configuration port (word address bits [3:2])
  localparam logic [1:0] RegSeekMs     = 2'd0;
  localparam logic [1:0] RegRotationMs = 2'd1;
  localparam logic [1:0] RegTransferMs = 2'd2;

  typedef struct packed {
    logic [15:0] cylinder;
    logic        first;
    logic        last;
    logic [15:0] request_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] total_movement;
    logic [15:0] max_seek;
    logic [31:0] avg_seek;
    logic [31:0] std_dev_seek;
    logic [31:0] throughput;
    logic        throughput_infinite;
    logic [47:0] avg_response_ms;
    logic        metrics_valid;
  } out_item_t;

  // Snapshot of one finished sequence, handed from front to back
  typedef struct packed {
    logic [31:0]            movement;
    logic [15:0]            largest;
    logic [15:0]            requests;
    logic [JobStepBits-1:0] nonzero;
    logic [47:0]            square_sum;
    logic [JobStepBits-1:0] steps;
  } job_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

/* hdl/sqm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module sqm_front import sqm_pkg::*; #(
  parameter int CYLINDER_BITS = 16,
  parameter int MAX_STEPS     = 65535
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  input  wire logic     full_i,
  output logic          push_o,
  output job_t          job_o
);

  localparam int SW = $clog2(MAX_STEPS + 1);
  localparam logic [15:0] CylMask =
    (CYLINDER_BITS >= 16) ? 16'hFFFF : 16'((1 << CYLINDER_BITS) - 1);

  logic [CYLINDER_BITS-1:0] prev_q, prev_d, cyl, seek_len;
  logic [SW-1:0]            step_q, step_d, nz_q, nz_d;
  logic [31:0]              sum_q, sum_d, dist32;
  logic [15:0]              big_q, big_d;
  logic [47:0]              sq_q, sq_d;
  logic [32:0]              sum_ext;
  logic [48:0]              sq_ext;
  logic [47:0]              dist_sq;
  logic                     accept;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign push_o     = accept && in_data_i.last;

  assign cyl      = CYLINDER_BITS'(in_data_i.cylinder & CylMask);
  assign seek_len = (cyl >= prev_q) ? cyl - prev_q : prev_q - cyl;
  assign dist32   = 32'(seek_len);
  assign dist_sq  = 48'(dist32 * dist32);
  assign sum_ext  = {1'b0, sum_q} + {1'b0, dist32};
  assign sq_ext   = {1'b0, sq_q} + {1'b0, dist_sq};

  always_comb begin
    prev_d = prev_q;
    step_d = step_q;
    nz_d   = nz_q;
    sum_d  = sum_q;
    big_d  = big_q;
    sq_d   = sq_q;
    if (in_data_i.first) begin
      prev_d = cyl;
      step_d = '0;
      nz_d   = '0;
      sum_d  = '0;
      big_d  = '0;
      sq_d   = '0;
    end else if (step_q < SW'(MAX_STEPS)) begin
      prev_d = cyl;
      step_d = step_q + 1'b1;
      sum_d  = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
      if (dist32 > 32'(big_q)) begin
        big_d = (dist32 > 32'hFFFF) ? 16'hFFFF : dist32[15:0];
      end
      if (dist32 != '0) begin
        nz_d = nz_q + 1'b1;
      end
      sq_d = sq_ext[48] ? 48'hFFFF_FFFF_FFFF : sq_ext[47:0];
    end
  end

  always_comb begin
    job_o.movement   = sum_d;
    job_o.largest    = big_d;
    job_o.requests   = in_data_i.request_count;
    job_o.nonzero    = JobStepBits'(nz_d);
    job_o.square_sum = sq_d;
    job_o.steps      = JobStepBits'(step_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      step_q <= '0;
      nz_q   <= '0;
      sum_q  <= '0;
      big_q  <= '0;
      sq_q   <= '0;
    end else if (accept) begin
      prev_q <= prev_d;
      step_q <= step_d;
      nz_q   <= nz_d;
      sum_q  <= sum_d;
      big_q  <= big_d;
      sq_q   <= sq_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/sqm_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module sqm_fifo import sqm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      job_o
);

  job_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign job_o   = slot_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

/* hdl/sqm_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module sqm_div import sqm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output logic          done_o,
  output logic [63:0]   quotient_o
);

  // Restoring division, one quotient bit a cycle
  logic [63:0] dvd_q;
  logic [31:0] rem_q, dsr_q, rem_d;
  logic [32:0] sh;
  logic        ge, busy_q, done_q;
  logic [6:0]  cnt_q;

  assign sh    = {rem_q, dvd_q[63]};
  assign ge    = sh >= {1'b0, dsr_q};
  assign rem_d = ge ? 32'(sh - {1'b0, dsr_q}) : sh[31:0];

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[62:0], ge};
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/sqm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module sqm_back import sqm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  input  wire job_t        job_i,
  output logic             job_pop_o,
  input  wire logic [31:0] seek_ms_i,
  input  wire logic [31:0] rot_ms_i,
  input  wire logic [31:0] xfer_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMul0  = 4'd1;
  localparam logic [3:0] StMul1  = 4'd2;
  localparam logic [3:0] StMul2  = 4'd3;
  localparam logic [3:0] StMul3  = 4'd4;
  localparam logic [3:0] StMul4  = 4'd5;
  localparam logic [3:0] StAvg   = 4'd6;
  localparam logic [3:0] StThr   = 4'd7;
  localparam logic [3:0] StResp  = 4'd8;
  localparam logic [3:0] StSqrt  = 4'd9;
  localparam logic [3:0] StStd   = 4'd10;
  localparam logic [3:0] StOut   = 4'd11;

  logic [3:0]   st_q;
  job_t         job_q;
  out_item_t    res_q;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_q, mm_q, sp_q;
  logic [71:0]  ks_q, diff;
  logic [103:0] rad_q;
  logic [53:0]  rem_q;
  logic [51:0]  root_q, root_d;
  logic [55:0]  rem_sh, trial;
  logic         sq_ge, stdz_q, stdz_now;
  logic [5:0]   cnt_q;
  div_req_t     req;
  logic         div_done;
  logic [63:0]  quo;
  logic [64:0]  resp_sum;

  sqm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign job_pop_o   = (st_q == StIdle) && job_valid_i;
  assign out_valid_o = st_q == StOut;
  assign out_data_o  = res_q;

  // One shared multiplier, operands chosen by the step
  always_comb begin
    mul_a = 32'(job_q.nonzero);
    mul_b = 32'(job_q.square_sum[23:0]);
    case (st_q)
      StMul0: begin
        mul_a = job_q.movement;
        mul_b = job_q.movement;
      end
      StMul2: begin
        mul_b = 32'(job_q.square_sum[47:24]);
      end
      StMul3: begin
        mul_a = seek_ms_i;
        mul_b = job_q.movement;
      end
      default: begin
      end
    endcase
  end

  assign diff     = ks_q - 72'(mm_q);
  assign stdz_now = (job_q.nonzero == '0) || (job_q.movement == '0) ||
                    (72'(mm_q) > ks_q);

  // Digit-by-digit square root, two radicand bits a step
  assign rem_sh = {rem_q, rad_q[103:102]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign sq_ge  = rem_sh >= trial;
  assign root_d = {root_q[50:0], sq_ge};

  assign resp_sum = {1'b0, quo} + 65'(rot_ms_i) + 65'(xfer_ms_i);

  always_comb begin
    req.start    = 1'b0;
    req.dividend = {32'd0, job_q.movement};
    req.divisor  = 32'(job_q.requests);
    case (st_q)
      StMul4: begin
        req.start    = 1'b1;
        req.dividend = 64'({job_q.movement, 16'd0});
      end
      StAvg: begin
        req.start = div_done;
        if (job_q.movement != '0) begin
          req.dividend = 64'({job_q.requests, 16'd0});
          req.divisor  = job_q.movement;
        end else begin
          req.dividend = sp_q;
          req.divisor  = 32'(job_q.steps);
        end
      end
      StThr: begin
        req.start    = div_done;
        req.dividend = sp_q;
        req.divisor  = 32'(job_q.steps);
      end
      StSqrt: begin
        req.start    = cnt_q == 6'd51;
        req.dividend = 64'(root_d);
        req.divisor  = 32'(job_q.nonzero);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= 64'(mul_a) * 64'(mul_b);
    case (st_q)
      StIdle: begin
        if (job_valid_i) begin
          job_q <= job_i;
          res_q <= '{metrics_valid: (job_i.requests != '0), default: '0};
        end
      end
      StMul1: mm_q <= mul_q;
      StMul2: ks_q <= 72'(mul_q);
      StMul3: ks_q <= ks_q + {mul_q[47:0], 24'd0};
      StMul4: begin
        sp_q   <= mul_q;
        stdz_q <= stdz_now;
        rad_q  <= {diff, 32'd0};
        res_q.total_movement <= job_q.movement;
        res_q.max_seek       <= job_q.largest;
      end
      StAvg: begin
        if (div_done) begin
          res_q.avg_seek <= (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
          res_q.throughput_infinite <= job_q.movement == '0;
        end
      end
      StThr: begin
        if (div_done) begin
          res_q.throughput <= (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
        end
      end
      StResp: begin
        if (div_done) begin
          res_q.avg_response_ms <= (resp_sum > 65'hFFFF_FFFF_FFFF) ?
                                   48'hFFFF_FFFF_FFFF : resp_sum[47:0];
          rem_q  <= '0;
          root_q <= '0;
          cnt_q  <= '0;
        end
      end
      StSqrt: begin
        rem_q  <= sq_ge ? 54'(rem_sh - trial) : rem_sh[53:0];
        root_q <= root_d;
        rad_q  <= {rad_q[101:0], 2'b00};
        cnt_q  <= cnt_q + 1'b1;
      end
      StStd: begin
        if (div_done) begin
          res_q.std_dev_seek <= (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      case (st_q)
        StIdle: begin
          if (job_valid_i) begin
            st_q <= (job_i.requests == '0 || job_i.steps == '0) ? StOut : StMul0;
          end
        end
        StMul0: st_q <= StMul1;
        StMul1: st_q <= StMul2;
        StMul2: st_q <= StMul3;
        StMul3: st_q <= StMul4;
        StMul4: st_q <= StAvg;
        StAvg: begin
          if (div_done) begin
            st_q <= (job_q.movement != '0) ? StThr : StResp;
          end
        end
        StThr: begin
          if (div_done) begin
            st_q <= StResp;
          end
        end
        StResp: begin
          if (div_done) begin
            st_q <= stdz_q ? StOut : StSqrt;
          end
        end
        StSqrt: begin
          if (cnt_q == 6'd51) begin
            st_q <= StStd;
          end
        end
        StStd: begin
          if (div_done) begin
            st_q <= StOut;
          end
        end
        StOut: begin
          if (!out_stall_i) begin
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/seek_sequence_metrics.sv */
// Seek sequence metrics.
// Input channel (in_valid_i / in_stall_o / in_data_i): one head position per
// transfer. An item with first set is the start head and opens a sequence;
// every other item is one seek step and, up to MAX_STEPS steps, is folded into
// the running totals in the cycle it is taken. An item with last set closes
// the sequence and queues one result.
// Output channel (out_valid_o / out_stall_i / out_data_o): one transfer per
// last item, in order. Derived metrics are Q16.16 (response time Q32.16).
// Throughput: one input item a cycle while the two-entry job queue has
// room; in_stall_o rises only when that queue is full.
// Each result comes from the back end's bit-serial divider (a handoff for
// each of up to four divisions) and the 52-step square root; a sequence
// with no requests or no steps skips them and goes straight to the output
// register.
// While out_stall_i is high the result holds in its register and the front
// end keeps accepting positions until the queue fills.
// Reset clears the totals, the queue and the timing registers to zero.
// Timing registers on the APB port: 0x0 seek per cylinder, 0x4 rotational
// latency, 0x8 transfer time; write them only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module seek_sequence_metrics import sqm_pkg::*; #(
  parameter int CYLINDER_BITS = 16,
  parameter int MAX_STEPS     = 65535
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] seek_q, rot_q, xfer_q;
  logic        wr_en;
  logic        push, full, job_valid, job_pop;
  job_t        push_job, head_job;

  // Configuration registers: written in the access phase
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seek_q <= '0;
      rot_q  <= '0;
      xfer_q <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegSeekMs:     seek_q <= pwdata;
        RegRotationMs: rot_q  <= pwdata;
        RegTransferMs: xfer_q <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegSeekMs:     prdata = seek_q;
      RegRotationMs: prdata = rot_q;
      RegTransferMs: prdata = xfer_q;
      default:       prdata = '0;
    endcase
  end

  // Front end: accumulate per step, snapshot the totals on the last item
  sqm_front #(
    .CYLINDER_BITS (CYLINDER_BITS),
    .MAX_STEPS     (MAX_STEPS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Decouple the single-cycle front from the slow back end
  sqm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .job_o   (head_job)
  );

  // Back end: divisions, square root and the output register
  sqm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .job_pop_o   (job_pop),
    .seek_ms_i   (seek_q),
    .rot_ms_i    (rot_q),
    .xfer_ms_i   (xfer_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

/* hdl/sqm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module sqm_checker import sqm_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_data_o,
  input wire logic      pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_no_requests_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.metrics_valid |->
      out_data_o.total_movement == '0 && out_data_o.avg_response_ms == '0 &&
      !out_data_o.throughput_infinite)
    else $error("metrics present without requests");

  a_infinite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.throughput_infinite |->
      out_data_o.total_movement == '0 && out_data_o.metrics_valid &&
      out_data_o.throughput == '0 && out_data_o.std_dev_seek == '0)
    else $error("infinite throughput with movement");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("config port not ready");

endmodule

bind seek_sequence_metrics sqm_checker u_sqm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);
`default_nettype wire
